/* sv/qye_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion yaw extraction package
// Shared types and constants for the heading pipeline and its CORDIC cells.
// ---------------------------------------------------------------------------
package qye_pkg;

  // Width of the CORDIC vector datapath. It holds the largest sine and cosine
  // terms after CORDIC gain at any component width.
  localparam int unsigned DataW  = 36;
  // Angle accumulator width, 2^31 counts per half turn.
  localparam int unsigned AngW   = 32;
  localparam int unsigned YawW   = 16;
  localparam int unsigned TabLen = 24;
  // Width of a scaled component product.
  localparam int unsigned ProdW  = 32;

  localparam logic [AngW-1:0] AngQuarterPos = 32'h4000_0000;
  localparam logic [AngW-1:0] AngQuarterNeg = 32'hC000_0000;
  localparam logic [AngW-1:0] AngRound      = 32'h0000_8000;

  // Arctangent of 2^-i in units of pi / 2^31.
  localparam logic [AngW-1:0] AtanTab [TabLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef logic signed [DataW-1:0] qye_vec_t;
  typedef logic [AngW-1:0]         qye_ang_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } qye_ctl_t;

endpackage

/* sv/quaternion_yaw_extract.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion yaw extraction
// Heading (ZYX yaw) of an attitude quaternion by CORDIC vectoring atan2.
// ---------------------------------------------------------------------------
// The block takes one quaternion request in every clock cycle and never
// raises busy_o. Each result appears on yaw_angle_o with done_o high for a
// single cycle, once its request has passed the registers for the component
// products, the sine and cosine sums with the half-plane rotation, each CORDIC
// cell, and the rounding. The receiver cannot stall the block, so it must
// capture every result in the cycle that done_o marks.
module quaternion_yaw_extract import qye_pkg::*; #(
  parameter int unsigned CORDIC_STAGES  = 16,
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [COMPONENT_BITS-1:0] quat_w_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_x_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_y_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_z_i,
  output logic                             done_o,
  output logic signed [YawW-1:0]           yaw_angle_o
);

  localparam int unsigned Latency = CORDIC_STAGES + 3;

  qye_ctl_t ctl_c [CORDIC_STAGES+1];
  qye_vec_t x_c   [CORDIC_STAGES+1];
  qye_vec_t y_c   [CORDIC_STAGES+1];
  qye_ang_t ang_c [CORDIC_STAGES+1];

  logic                   req;
  qye_ang_t               ang_rnd;
  logic signed [YawW-1:0] yaw_d;
  logic signed [YawW-1:0] yaw_q;
  logic                   done_q;

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  qye_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .quat_w_i(quat_w_i),
    .quat_x_i(quat_x_i),
    .quat_y_i(quat_y_i),
    .quat_z_i(quat_z_i),
    .ctl_o   (ctl_c[0]),
    .x_o     (x_c[0]),
    .y_o     (y_c[0]),
    .ang_o   (ang_c[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    qye_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_c[g]),
      .x_i   (x_c[g]),
      .y_i   (y_c[g]),
      .ang_i (ang_c[g]),
      .ctl_o (ctl_c[g+1]),
      .x_o   (x_c[g+1]),
      .y_o   (y_c[g+1]),
      .ang_o (ang_c[g+1])
    );
  end

  always_comb begin
    ang_rnd = ang_c[CORDIC_STAGES] + AngRound;
    if (ctl_c[CORDIC_STAGES].zero) begin
      yaw_d = '0;
    end else begin
      yaw_d = ang_rnd[AngW-1 -: YawW];
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q <= yaw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_c[CORDIC_STAGES].valid;
    end
  end

  assign done_o      = done_q;
  assign yaw_angle_o = yaw_q;

  a_done_follows_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##Latency done_o)
    else $error("Result strobe missing after a request.");

  a_done_has_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req, Latency))
    else $error("Result strobe without a matching request.");

  a_zero_quat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && quat_w_i == '0 && quat_x_i == '0 && quat_y_i == '0 && quat_z_i == '0)
      |-> ##Latency (yaw_angle_o == '0))
    else $error("Zero quaternion did not give a zero heading.");

endmodule

/* sv/qye_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion yaw front end
// Forms the sine and cosine heading terms from the quaternion components and
// rotates the vector into the right half plane for the CORDIC cells.
// ---------------------------------------------------------------------------
module qye_front import qye_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_w_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_x_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_y_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_z_i,
  output qye_ctl_t                         ctl_o,
  output qye_vec_t                         x_o,
  output qye_vec_t                         y_o,
  output qye_ang_t                         ang_o
);

  localparam int unsigned PW     = 2 * COMPONENT_BITS;
  localparam int unsigned Shift  = (COMPONENT_BITS > 16) ? (PW - 32) : 0;
  localparam int unsigned NProd  = 6;

  logic signed [COMPONENT_BITS-1:0] op_a [NProd];
  logic signed [COMPONENT_BITS-1:0] op_b [NProd];
  logic signed [ProdW-1:0]          prod_d [NProd];
  logic signed [ProdW-1:0]          prod_q [NProd];
  logic                             valid1_q;

  logic signed [PW-1:0]    full_prod [NProd];
  qye_vec_t                vs;
  qye_vec_t                vc;
  qye_ctl_t                ctl_d;
  qye_ctl_t                ctl_q;
  qye_vec_t                x_d;
  qye_vec_t                x_q;
  qye_vec_t                y_d;
  qye_vec_t                y_q;
  qye_ang_t                ang_d;
  qye_ang_t                ang_q;

  // Product order: wz, xy, ww, xx, yy, zz.
  always_comb begin
    op_a[0] = quat_w_i;
    op_b[0] = quat_z_i;
    op_a[1] = quat_x_i;
    op_b[1] = quat_y_i;
    op_a[2] = quat_w_i;
    op_b[2] = quat_w_i;
    op_a[3] = quat_x_i;
    op_b[3] = quat_x_i;
    op_a[4] = quat_y_i;
    op_b[4] = quat_y_i;
    op_a[5] = quat_z_i;
    op_b[5] = quat_z_i;
    for (int i = 0; i < NProd; i++) begin
      full_prod[i] = PW'(op_a[i]) * PW'(op_b[i]);
      prod_d[i]    = ProdW'(full_prod[i] >>> Shift);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NProd; i++) begin
      prod_q[i] <= prod_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= req_i;
    end
  end

  always_comb begin
    vs = (DataW'(prod_q[0]) + DataW'(prod_q[1])) <<< 1;
    vc = DataW'(prod_q[2]) + DataW'(prod_q[3]) - DataW'(prod_q[4]) - DataW'(prod_q[5]);
    ctl_d.valid = valid1_q;
    ctl_d.zero  = (vs == '0) && (vc == '0);
    x_d   = vc;
    y_d   = vs;
    ang_d = '0;
    if (vc < 0) begin
      if (vs >= 0) begin
        ang_d = AngQuarterPos;
        x_d   = vs;
        y_d   = -vc;
      end else begin
        ang_d = AngQuarterNeg;
        x_d   = -vs;
        y_d   = vc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

/* sv/qye_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion yaw CORDIC cell
// One registered vectoring micro-rotation that drives the y term toward zero.
// ---------------------------------------------------------------------------
module qye_cell import qye_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  qye_ctl_t ctl_i,
  input  qye_vec_t x_i,
  input  qye_vec_t y_i,
  input  qye_ang_t ang_i,
  output qye_ctl_t ctl_o,
  output qye_vec_t x_o,
  output qye_vec_t y_o,
  output qye_ang_t ang_o
);

  qye_vec_t dx;
  qye_vec_t dy;
  qye_vec_t x_d;
  qye_vec_t x_q;
  qye_vec_t y_d;
  qye_vec_t y_q;
  qye_ang_t ang_d;
  qye_ang_t ang_q;
  qye_ctl_t ctl_q;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (y_i >= 0) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + AtanTab[STAGE];
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - AtanTab[STAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

/* tb/sv/quaternion_yaw_extract_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion yaw extraction testbench
// Sends quaternion requests with random gaps and checks every heading that
// comes back against a bit-exact predictor of the CORDIC atan2 pipeline. A
// directed table covers the extreme components and the degenerate headings.
// Random requests follow, including many whose sine and cosine terms cancel.
// ---------------------------------------------------------------------------
module quaternion_yaw_extract_tb;
  import qye_pkg::*;

  localparam int unsigned QuatW       = 16;
  localparam int unsigned Stages      = 16;
  localparam int unsigned Latency     = Stages + 3;
  localparam int unsigned RandomCount = 1030;
  localparam int unsigned IdleLimit   = 1000;
  localparam longint      QuarterTurn = 64'sd1073741824;

  localparam longint AtanUnits [24] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331,  21354465,  10679838,  5340245,
    2670163,   1335087,   667544,    333772,
    166886,    83443,     41722,     20861,
    10430,     5215,      2608,      1304,
    652,       326,       163,       81
  };

  typedef logic signed [QuatW-1:0] comp_t;
  typedef logic signed [YawW-1:0]  yaw_t;

  typedef enum int unsigned {
    CompWide,
    CompSmall,
    CompEdge
  } comp_style_e;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
    logic  typed;
    yaw_t  yaw;
  } quat_row_t;

  // Rows marked typed carry a heading that follows from the terms alone.
  localparam quat_row_t DirectedRows [20] = '{
    '{0,      0,      0,      0,      1'b1, 0},
    '{16384,  0,      16384,  0,      1'b1, 0},
    '{0,      -32768, 0,      -32768, 1'b1, 0},
    '{32767,  0,      0,      0,      1'b0, 0},
    '{-32768, 0,      0,      0,      1'b0, 0},
    '{0,      0,      0,      32767,  1'b0, 0},
    '{0,      0,      0,      -32768, 1'b0, 0},
    '{0,      0,      32767,  0,      1'b0, 0},
    '{0,      32767,  0,      0,      1'b0, 0},
    '{23170,  0,      0,      23170,  1'b0, 0},
    '{23170,  0,      0,      -23170, 1'b0, 0},
    '{32767,  32767,  32767,  32767,  1'b0, 0},
    '{-32768, -32768, -32768, -32768, 1'b0, 0},
    '{-32768, 32767,  -32768, 32767,  1'b0, 0},
    '{1,      0,      0,      -32767, 1'b0, 0},
    '{1,      0,      0,      1,      1'b0, 0},
    '{1,      0,      0,      -1,     1'b0, 0},
    '{0,      1,      1,      0,      1'b0, 0},
    '{-1,     -1,     -1,     -1,     1'b0, 0},
    '{-32768, 0,      0,      1,      1'b0, 0}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  comp_t quat_w_i;
  comp_t quat_x_i;
  comp_t quat_y_i;
  comp_t quat_z_i;
  logic  done_o;
  yaw_t  yaw_angle_o;

  yaw_t        expected_yaw_q [$];
  int unsigned mismatches;
  int unsigned idle_cycles;

  quaternion_yaw_extract #(
    .CORDIC_STAGES (Stages),
    .COMPONENT_BITS(QuatW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .quat_w_i   (quat_w_i),
    .quat_x_i   (quat_x_i),
    .quat_y_i   (quat_y_i),
    .quat_z_i   (quat_z_i),
    .done_o     (done_o),
    .yaw_angle_o(yaw_angle_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic yaw_t heading_of(comp_t w, comp_t x, comp_t y, comp_t z);
    longint      sn;
    longint      cs;
    longint      t;
    longint      dx;
    longint      dy;
    longint      ang;
    logic [63:0] rounded;
    sn  = 2 * (longint'(w) * longint'(z) + longint'(x) * longint'(y));
    cs  = longint'(w) * longint'(w) + longint'(x) * longint'(x)
        - longint'(y) * longint'(y) - longint'(z) * longint'(z);
    ang = 0;
    if (sn == 0 && cs == 0) return '0;
    // Fold the left half plane onto the right one before the iterations.
    if (cs < 0) begin
      t = cs;
      if (sn >= 0) begin
        ang = QuarterTurn;
        cs  = sn;
        sn  = -t;
      end else begin
        ang = -QuarterTurn;
        cs  = -sn;
        sn  = t;
      end
    end
    for (int i = 0; i < Stages; i++) begin
      dx = sn >>> i;
      dy = cs >>> i;
      if (sn >= 0) begin
        cs  += dx;
        sn  -= dy;
        ang += AtanUnits[i];
      end else begin
        cs  -= dx;
        sn  += dy;
        ang -= AtanUnits[i];
      end
    end
    rounded = ang + 64'sd32768;
    return rounded[31:16];
  endfunction

  function automatic comp_t rand_comp(comp_style_e style);
    comp_t edges [6] = '{-32768, -32767, -1, 0, 1, 32767};
    case (style)
      CompSmall: return comp_t'($urandom_range(0, 8) - 4);
      CompEdge:  return edges[$urandom_range(0, 5)];
      default:   return comp_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_quat(comp_t w, comp_t x, comp_t y, comp_t z, bit typed, yaw_t yaw);
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    start_i  <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_yaw_q.push_back(typed ? yaw : heading_of(w, x, y, z));
  endtask

  task automatic idle_gap(int unsigned cycles);
    if (cycles > 0) begin
      start_i  <= 1'b0;
      quat_w_i <= comp_t'($urandom);
      quat_x_i <= comp_t'($urandom);
      quat_y_i <= comp_t'($urandom);
      quat_z_i <= comp_t'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_heading
    yaw_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_yaw_q.size() == 0) begin
        $error("yaw_angle: expected none, actual %0d", yaw_angle_o);
        mismatches++;
      end else begin
        want = expected_yaw_q.pop_front();
        if (yaw_angle_o !== want) begin
          $error("yaw_angle: expected %0d, actual %0d", want, yaw_angle_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    comp_style_e style;
    comp_t       a;
    comp_t       b;
    mismatches  = 0;
    idle_cycles = 0;
    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    quat_w_i <= '0;
    quat_x_i <= '0;
    quat_y_i <= '0;
    quat_z_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[n]) begin
      issue_quat(DirectedRows[n].w, DirectedRows[n].x, DirectedRows[n].y,
                 DirectedRows[n].z, DirectedRows[n].typed, DirectedRows[n].yaw);
      idle_gap(pick_gap(n < 8));
    end

    for (int n = 0; n < RandomCount; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        style = (pick < 70) ? CompWide : ((pick < 80) ? CompSmall : CompEdge);
        issue_quat(rand_comp(style), rand_comp(style), rand_comp(style),
                   rand_comp(style), 1'b0, '0);
      end else begin
        // These forms cancel both terms unless negation overflows.
        a = rand_comp(CompWide);
        b = rand_comp((pick < 94) ? CompWide : CompSmall);
        if (pick[0]) begin
          issue_quat(a, b, a, -b, 1'b0, '0);
        end else begin
          issue_quat(a, b, -a, b, 1'b0, '0);
        end
      end
      idle_gap(pick_gap((n % 128) < 40));
    end
    start_i <= 1'b0;

    wait (expected_yaw_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
    if (mismatches == 0 && expected_yaw_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
